[src/stereo_peak_clip_meter_top_defines.svh]
// ---------------------------------------------------------------------------
// stereo peak clip meter assertion macros
// shared concurrent assertion shorthands, sampled on clock, off in reset
// ---------------------------------------------------------------------------
`ifndef STEREO_PEAK_CLIP_METER_TOP_DEFINES_SVH
`define STEREO_PEAK_CLIP_METER_TOP_DEFINES_SVH

// same-cycle implication
`define SPCM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPCM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/spcm_pkg.sv]
// ---------------------------------------------------------------------------
// spcm_pkg
// types and constants shared by the stereo peak clip meter
// ---------------------------------------------------------------------------
`default_nettype none

package spcm_pkg;

   localparam int KIND_W   = 3;
   localparam int SAMPLE_W = 16;
   localparam int PEAK_W   = 17;
   localparam int HOLD_W   = 17;
   localparam int SEQ_W    = 32;
   localparam int OUT_CNT_W = 32;

   localparam logic [SAMPLE_W-1:0] RAIL_HIGH = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] RAIL_LOW  = 16'h8000;
   localparam logic [PEAK_W-1:0]   MAG_BASE  = 17'h10000;

   typedef enum logic [KIND_W-1:0] {
      KIND_FRAME      = 3'd0,
      KIND_PERIOD_END = 3'd1,
      KIND_UNDERRUN   = 3'd2,
      KIND_OVERRUN    = 3'd3,
      KIND_PROD_ARM   = 3'd4,
      KIND_PROD_TICK  = 3'd5,
      KIND_READ       = 3'd6,
      KIND_CLEAR      = 3'd7
   } kind_type;

   // decoded request, every strobe already qualified by the handshake
   typedef struct packed {
      logic frame;
      logic period_end;
      logic underrun;
      logic overrun;
      logic prod_arm;
      logic prod_tick;
      logic read;
      logic clear;
      logic dir;
      logic hold_reset;
   } ctl_type;

endpackage

`default_nettype wire

[src/spcm_if.sv]
// ---------------------------------------------------------------------------
// spcm request and response channels
// valid/ready channels carrying one meter request or one snapshot
// ---------------------------------------------------------------------------
`default_nettype none

interface spcm_req_if;
   import spcm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [KIND_W-1:0]          kind;
   logic                       direction;
   logic signed [SAMPLE_W-1:0] left_sample;
   logic signed [SAMPLE_W-1:0] right_sample;
   logic [SEQ_W-1:0]           prod_sequence;
   logic                       hold_reset;

   modport source (output valid, kind, direction, left_sample, right_sample,
                   prod_sequence, hold_reset, input ready);
   modport sink   (input valid, kind, direction, left_sample, right_sample,
                   prod_sequence, hold_reset, output ready);
endinterface

interface spcm_rsp_if;
   import spcm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 snap_direction;
   logic [HOLD_W-1:0]    peak_hold_left;
   logic [HOLD_W-1:0]    peak_hold_right;
   logic [OUT_CNT_W-1:0] clip_regions;
   logic [OUT_CNT_W-1:0] underruns;
   logic [OUT_CNT_W-1:0] overruns;

   modport source (output valid, snap_direction, peak_hold_left, peak_hold_right,
                   clip_regions, underruns, overruns, input ready);
   modport sink   (input valid, snap_direction, peak_hold_left, peak_hold_right,
                   clip_regions, underruns, overruns, output ready);
endinterface

`default_nettype wire

[src/spcm_lane.sv]
// ---------------------------------------------------------------------------
// spcm_lane
// one audio channel: magnitude, rail detect, period peak and peak hold
// ---------------------------------------------------------------------------
`default_nettype none

module spcm_lane (
   input  wire                               clock,
   input  wire                               reset,
   input  spcm_pkg::ctl_type                 ctl,
   input  wire                               restart,
   input  wire  signed [spcm_pkg::SAMPLE_W-1:0] sample,
   output logic                              at_rail,
   output logic [spcm_pkg::HOLD_W-1:0]       hold_out
);
   import spcm_pkg::*;

   logic [PEAK_W-1:0] peak_ff [2];
   logic [PEAK_W-1:0] peak_in [2];
   logic [HOLD_W-1:0] hold_ff [2];
   logic [HOLD_W-1:0] hold_in [2];
   logic [PEAK_W-1:0] mag;
   logic [HOLD_W-1:0] dbl;

   // |sample| needs 17 bits for the negative rail
   always_comb begin
      if (sample[SAMPLE_W-1]) begin
         mag = MAG_BASE - {1'b0, sample};
      end else begin
         mag = {1'b0, sample};
      end
      at_rail = (sample == RAIL_HIGH) || (sample == RAIL_LOW);
   end

   // peak never exceeds 32768, so the doubled value fits in 17 bits
   assign dbl = {peak_ff[ctl.dir][PEAK_W-2:0], 1'b0};

   always_comb begin
      peak_in = peak_ff;
      hold_in = hold_ff;
      if (ctl.clear) begin
         peak_in[0] = '0;
         peak_in[1] = '0;
         hold_in[0] = '0;
         hold_in[1] = '0;
      end else if (ctl.frame) begin
         if (mag > peak_ff[ctl.dir]) begin
            peak_in[ctl.dir] = mag;
         end
      end else if (ctl.period_end) begin
         if (restart || (dbl > hold_ff[ctl.dir])) begin
            hold_in[ctl.dir] = dbl;
         end
         peak_in[ctl.dir] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff[0] <= '0;
         peak_ff[1] <= '0;
         hold_ff[0] <= '0;
         hold_ff[1] <= '0;
      end else begin
         peak_ff <= peak_in;
         hold_ff <= hold_in;
      end
   end

   assign hold_out = hold_ff[ctl.dir];

endmodule

`default_nettype wire

[src/spcm_merge.sv]
// ---------------------------------------------------------------------------
// spcm_merge
// combines lane rail flags into clip regions; event and stall counters
// ---------------------------------------------------------------------------
`default_nettype none

`include "stereo_peak_clip_meter_top_defines.svh"

module spcm_merge #(
   parameter int COUNTER_WIDTH = 32
) (
   input  wire                            clock,
   input  wire                            reset,
   input  spcm_pkg::ctl_type              ctl,
   input  wire                            rail_left,
   input  wire                            rail_right,
   input  wire  [spcm_pkg::SEQ_W-1:0]     seq,
   output logic                           restart,
   output logic [COUNTER_WIDTH-1:0]       clip_out,
   output logic [COUNTER_WIDTH-1:0]       underrun_out,
   output logic [COUNTER_WIDTH-1:0]       overrun_out
);
   import spcm_pkg::*;

   localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

   logic                     run_open_ff [2];
   logic                     run_open_in [2];
   logic [COUNTER_WIDTH-1:0] region_ff [2];
   logic [COUNTER_WIDTH-1:0] region_in [2];
   logic [COUNTER_WIDTH-1:0] clip_ff [2];
   logic [COUNTER_WIDTH-1:0] clip_in [2];
   logic                     pending_ff [2];
   logic                     pending_in [2];
   logic [COUNTER_WIDTH-1:0] underrun_ff, underrun_in;
   logic [COUNTER_WIDTH-1:0] overrun_ff, overrun_in;
   logic                     armed_ff, armed_in;
   logic [SEQ_W-1:0]         arm_seq_ff, arm_seq_in;
   logic [SEQ_W-1:0]         last_seq_ff, last_seq_in;
   logic [COUNTER_WIDTH:0]   clip_sum;
   logic                     any_rail;
   logic                     stall_hit;

   assign any_rail  = rail_left || rail_right;
   assign clip_sum  = {1'b0, clip_ff[ctl.dir]} + {1'b0, region_ff[ctl.dir]};
   assign stall_hit = ctl.prod_tick && armed_ff && (seq == last_seq_ff);

   always_comb begin
      run_open_in = run_open_ff;
      region_in   = region_ff;
      clip_in     = clip_ff;
      pending_in  = pending_ff;
      underrun_in = underrun_ff;
      overrun_in  = overrun_ff;
      armed_in    = armed_ff;
      arm_seq_in  = arm_seq_ff;
      last_seq_in = last_seq_ff;
      if (ctl.clear) begin
         for (int i = 0; i < 2; i++) begin
            run_open_in[i] = 1'b0;
            region_in[i]   = '0;
            clip_in[i]     = '0;
            pending_in[i]  = 1'b0;
         end
         underrun_in = '0;
         overrun_in  = '0;
         armed_in    = 1'b0;
         arm_seq_in  = '0;
         last_seq_in = '0;
      end else begin
         if (ctl.frame) begin
            if (any_rail) begin
               if (!run_open_ff[ctl.dir]) begin
                  run_open_in[ctl.dir] = 1'b1;
                  if (region_ff[ctl.dir] != CNT_MAX) begin
                     region_in[ctl.dir] = region_ff[ctl.dir] + 1'b1;
                  end
               end
            end else begin
               run_open_in[ctl.dir] = 1'b0;
            end
         end
         if (ctl.period_end) begin
            clip_in[ctl.dir]    = clip_sum[COUNTER_WIDTH] ? CNT_MAX
                                                          : clip_sum[COUNTER_WIDTH-1:0];
            region_in[ctl.dir]  = '0;
            pending_in[ctl.dir] = 1'b0;
         end
         if (ctl.read && ctl.hold_reset) begin
            pending_in[ctl.dir] = 1'b1;
         end
         if ((ctl.underrun || stall_hit) && (underrun_ff != CNT_MAX)) begin
            underrun_in = underrun_ff + 1'b1;
         end
         if (ctl.overrun && (overrun_ff != CNT_MAX)) begin
            overrun_in = overrun_ff + 1'b1;
         end
         if (ctl.prod_arm) begin
            armed_in    = 1'b0;
            arm_seq_in  = seq;
            last_seq_in = seq;
         end
         if (ctl.prod_tick) begin
            if (armed_ff) begin
               last_seq_in = seq;
            end else if (seq != arm_seq_ff) begin
               armed_in    = 1'b1;
               last_seq_in = seq;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            run_open_ff[i] <= 1'b0;
            region_ff[i]   <= '0;
            clip_ff[i]     <= '0;
            pending_ff[i]  <= 1'b0;
         end
         underrun_ff <= '0;
         overrun_ff  <= '0;
         armed_ff    <= 1'b0;
         arm_seq_ff  <= '0;
         last_seq_ff <= '0;
      end else begin
         run_open_ff <= run_open_in;
         region_ff   <= region_in;
         clip_ff     <= clip_in;
         pending_ff  <= pending_in;
         underrun_ff <= underrun_in;
         overrun_ff  <= overrun_in;
         armed_ff    <= armed_in;
         arm_seq_ff  <= arm_seq_in;
         last_seq_ff <= last_seq_in;
      end
   end

   assign restart      = pending_ff[ctl.dir];
   assign clip_out     = clip_ff[ctl.dir];
   assign underrun_out = underrun_ff;
   assign overrun_out  = overrun_ff;

   `SPCM_ASSERT_NEXT(a_underrun_monotonic, !ctl.clear, underrun_ff >= $past(underrun_ff), "underrun count dropped without clear")
   `SPCM_ASSERT_NOW(a_armed_from_tick, $rose(armed_ff), $past(ctl.prod_tick), "stall detector armed without a tick")
   `SPCM_ASSERT_NEXT(a_clear_disarms, ctl.clear, !armed_ff && (underrun_ff == '0), "clear left detector state")

endmodule

`default_nettype wire

[src/stereo_peak_clip_meter_top.sv]
// ---------------------------------------------------------------------------
// stereo_peak_clip_meter_top
// stereo peak and clip meter for output and capture directions
// ---------------------------------------------------------------------------
//  channel | dir | handshake          | carries
//  req     | in  | valid/ready        | kind, direction, samples, seq, hold_reset
//  rsp     | out | valid/ready        | snapshot of holds and counters (read only)
//
//  one request per cycle while req ready is high; every request updates state at its accept edge
//  a read request's snapshot is loaded into the response register at its accept edge
//  req ready drops only while a snapshot waits and rsp ready is low
//  synchronous reset clears all meter state and empties the response register
// ---------------------------------------------------------------------------
`default_nettype none

`include "stereo_peak_clip_meter_top_defines.svh"

module stereo_peak_clip_meter_top #(
   parameter int COUNTER_WIDTH = 32
) (
   input  wire        clock,
   input  wire        reset,
   spcm_req_if.sink   req_chan,
   spcm_rsp_if.source rsp_chan
);
   import spcm_pkg::*;

   ctl_type                  ctl;
   logic                     req_fire;
   logic                     rail_left, rail_right;
   logic                     restart;
   logic [HOLD_W-1:0]        hold_left, hold_right;
   logic [COUNTER_WIDTH-1:0] clip_cnt, underrun_cnt, overrun_cnt;

   // response register, valid is control state, payload needs no reset
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 snap_dir_ff;
   logic [HOLD_W-1:0]    hold_left_ff, hold_right_ff;
   logic [OUT_CNT_W-1:0] clip_ff, underrun_ff, overrun_ff;

   // take a request whenever the response slot is free or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // decode the request kind into qualified strobes for the lanes and merge
   always_comb begin
      ctl            = '0;
      ctl.dir        = req_chan.direction;
      ctl.hold_reset = req_chan.hold_reset;
      if (req_fire) begin
         unique case (kind_type'(req_chan.kind))
            KIND_FRAME:      ctl.frame      = 1'b1;
            KIND_PERIOD_END: ctl.period_end = 1'b1;
            KIND_UNDERRUN:   ctl.underrun   = 1'b1;
            KIND_OVERRUN:    ctl.overrun    = 1'b1;
            KIND_PROD_ARM:   ctl.prod_arm   = 1'b1;
            KIND_PROD_TICK:  ctl.prod_tick  = 1'b1;
            KIND_READ:       ctl.read       = 1'b1;
            KIND_CLEAR:      ctl.clear      = 1'b1;
         endcase
      end
   end

   // left and right lanes run side by side on the two samples of a frame
   spcm_lane u_lane_left (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .restart  (restart),
      .sample   (req_chan.left_sample),
      .at_rail  (rail_left),
      .hold_out (hold_left)
   );

   spcm_lane u_lane_right (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .restart  (restart),
      .sample   (req_chan.right_sample),
      .at_rail  (rail_right),
      .hold_out (hold_right)
   );

   // merge: either lane at the rail makes a clip frame; counters and stall detect
   spcm_merge #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .rail_left    (rail_left),
      .rail_right   (rail_right),
      .seq          (req_chan.prod_sequence),
      .restart      (restart),
      .clip_out     (clip_cnt),
      .underrun_out (underrun_cnt),
      .overrun_out  (overrun_cnt)
   );

   // response valid: load on read, drop when drained with no new read
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // snapshot is taken from state before this request's own update
   always_ff @(posedge clock) begin
      if (ctl.read) begin
         snap_dir_ff   <= ctl.dir;
         hold_left_ff  <= hold_left;
         hold_right_ff <= hold_right;
         clip_ff       <= OUT_CNT_W'(clip_cnt);
         underrun_ff   <= ctl.dir ? '0 : OUT_CNT_W'(underrun_cnt);
         overrun_ff    <= ctl.dir ? OUT_CNT_W'(overrun_cnt) : '0;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.snap_direction  = snap_dir_ff;
   assign rsp_chan.peak_hold_left  = hold_left_ff;
   assign rsp_chan.peak_hold_right = hold_right_ff;
   assign rsp_chan.clip_regions    = clip_ff;
   assign rsp_chan.underruns       = underrun_ff;
   assign rsp_chan.overruns        = overrun_ff;

   `SPCM_ASSERT_NEXT(a_read_gives_rsp, ctl.read, rsp_valid_ff, "read gave no response")
   `SPCM_ASSERT_NEXT(a_drain_empties, !ctl.read && rsp_chan.ready, !rsp_valid_ff, "stale rsp")
   `SPCM_ASSERT_NOW(a_free_slot_ready, !rsp_valid_ff, req_chan.ready, "stall with empty slot")

endmodule

`default_nettype wire
